### rtl/btad_pkg.sv
// ----------------------------------------------------------------------------
// btad_pkg: shared types and constants of the byte to ASCII digit dump
// Character codes, digit mode codes, register indexes and the descriptor
// that travels from the front classifier to the character serializer.
// ----------------------------------------------------------------------------
package btad_pkg;

	// digit mode codes (digit_mode register)
	localparam logic [2:0] MODE_HEX = 3'd0;
	localparam logic [2:0] MODE_OCT = 3'd1;
	localparam logic [2:0] MODE_B4  = 3'd2;
	localparam logic [2:0] MODE_BIN = 3'd3;
	localparam logic [2:0] MODE_DEC = 3'd4;

	// configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_MODE = 1'b0;
	localparam logic [REG_IDX_W-1:0] REG_LINE = 1'b1;

	localparam int LINE_W = 12;
	localparam int COL_W  = 13;
	localparam logic [LINE_W-1:0] LINE_DEFAULT = 12'd64;
	localparam logic [LINE_W-1:0] LINE_MIN     = 12'd3;

	// input action codes
	localparam logic ACT_DATA  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	// ASCII codes
	localparam logic [6:0] CH_NL     = 7'd10;
	localparam logic [6:0] CH_SP     = 7'd32;
	localparam logic [6:0] CH_ZERO   = 7'd48;
	localparam logic [6:0] CH_LETTER = 7'd55;

	// descriptor queue depth
	localparam int QDEPTH = 4;

	// one accepted item, classified
	typedef struct packed {
		logic       flush;    // emit a single newline
		logic [2:0] mode;     // normalized digit mode
		logic [7:0] data;     // raw byte
		logic [1:0] hund;     // decimal hundreds digit
		logic [3:0] tens;     // decimal tens digit
		logic [3:0] ones;     // decimal units digit
		logic       nl;       // newline after the digits
		logic [3:0] last_idx; // index of the final character
	} desc_t;

	// digit value to ASCII, uppercase letters for ten and up
	function automatic logic [6:0] digit_char(input logic [3:0] v);
		digit_char = (v <= 4'd9) ? (CH_ZERO + 7'(v)) : (CH_LETTER + 7'(v));
	endfunction

endpackage

### rtl/btad_front.sv
// ----------------------------------------------------------------------------
// btad_front: input classifier
// Accepts input beats, holds the configuration registers and the column
// count, and pushes one descriptor per item that produces characters.
// ----------------------------------------------------------------------------
module btad_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // data_byte
	input  logic                            s_tuser,   // action
	input  logic                            cfg_we,
	input  logic [btad_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [btad_pkg::LINE_W-1:0]     cfg_wdata,
	input  logic                            q_full,
	output logic                            q_push,
	output btad_pkg::desc_t                 q_wdesc
);

	logic [2:0]                  mode_q;
	logic [btad_pkg::LINE_W-1:0] line_len_q;
	logic [btad_pkg::COL_W-1:0]  col_q;

	logic                        acc;
	logic                        is_flush;
	logic [2:0]                  mode_n;
	logic [3:0]                  nchar;
	logic [btad_pkg::LINE_W-1:0] limit;
	logic [btad_pkg::COL_W-1:0]  col_sum;
	logic                        nl;
	logic [1:0]                  hund;
	logic [7:0]                  rem;
	logic [14:0]                 tens_prod;
	logic [3:0]                  tens;
	logic [7:0]                  tens_x10;
	logic [3:0]                  ones;

	assign s_tready = !q_full;
	assign acc      = s_tvalid && !q_full;
	assign is_flush = (s_tuser == btad_pkg::ACT_FLUSH);

	// normalize the mode and get the character count
	always_comb begin
		case (mode_q)
			btad_pkg::MODE_OCT: begin
				mode_n = btad_pkg::MODE_OCT;
				nchar  = 4'd3;
			end
			btad_pkg::MODE_B4: begin
				mode_n = btad_pkg::MODE_B4;
				nchar  = 4'd4;
			end
			btad_pkg::MODE_BIN: begin
				mode_n = btad_pkg::MODE_BIN;
				nchar  = 4'd8;
			end
			btad_pkg::MODE_DEC: begin
				mode_n = btad_pkg::MODE_DEC;
				nchar  = 4'd4;
			end
			default: begin
				mode_n = btad_pkg::MODE_HEX;
				nchar  = 4'd2;
			end
		endcase
	end

	// line wrap decision
	assign limit   = (line_len_q < btad_pkg::LINE_MIN) ? btad_pkg::LINE_DEFAULT : line_len_q;
	assign col_sum = col_q + btad_pkg::COL_W'(nchar);
	assign nl      = (col_sum >= {1'b0, limit});

	// decimal digits: compare for hundreds, reciprocal multiply for tens
	always_comb begin
		if (s_tdata >= 8'd200) begin
			hund = 2'd2;
			rem  = s_tdata - 8'd200;
		end else if (s_tdata >= 8'd100) begin
			hund = 2'd1;
			rem  = s_tdata - 8'd100;
		end else begin
			hund = 2'd0;
			rem  = s_tdata;
		end
	end

	assign tens_prod = 15'(rem) * 15'd205;
	assign tens      = tens_prod[14:11];
	assign tens_x10  = {1'b0, tens, 3'b000} + {3'b000, tens, 1'b0};
	assign ones      = 4'(rem - tens_x10);

	// build the descriptor
	always_comb begin
		q_wdesc.flush    = is_flush;
		q_wdesc.mode     = mode_n;
		q_wdesc.data     = s_tdata;
		q_wdesc.hund     = hund;
		q_wdesc.tens     = tens;
		q_wdesc.ones     = ones;
		q_wdesc.nl       = nl;
		q_wdesc.last_idx = is_flush ? 4'd0 : (nchar - 4'd1 + 4'(nl));
	end

	// drop a flush on an empty line
	assign q_push = acc && !(is_flush && (col_q == '0));

	// hold configuration and column count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= btad_pkg::MODE_HEX;
			line_len_q <= btad_pkg::LINE_DEFAULT;
			col_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					btad_pkg::REG_MODE: mode_q     <= cfg_wdata[2:0];
					btad_pkg::REG_LINE: line_len_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (acc) begin
				if (is_flush || nl) begin
					col_q <= '0;
				end else begin
					col_q <= col_sum;
				end
			end
		end
	end

endmodule

### rtl/btad_queue.sv
// ----------------------------------------------------------------------------
// btad_queue: descriptor queue
// Short first-in first-out store between classifier and serializer.
// ----------------------------------------------------------------------------
module btad_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  btad_pkg::desc_t wdesc,
	output logic            full,
	input  logic            pop,
	output btad_pkg::desc_t rdesc,
	output logic            valid
);

	localparam int PTR_W = $clog2(btad_pkg::QDEPTH);
	localparam int CNT_W = $clog2(btad_pkg::QDEPTH + 1);

	btad_pkg::desc_t  ent_q [btad_pkg::QDEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(btad_pkg::QDEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && !full;
	assign do_pop  = pop && valid;
	assign rdesc   = ent_q[rd_ptr_q];

	// store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= wdesc;
		end
	end

	// advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/btad_back.sv
// ----------------------------------------------------------------------------
// btad_back: character serializer
// Walks the head descriptor into the output register, one character per cycle
// while it is free or taken, and pops the descriptor with its final character.
// ----------------------------------------------------------------------------
module btad_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  btad_pkg::desc_t q_rdesc,
	output logic            q_pop,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,   // char_code, zero pad
	output logic            m_tlast    // last_of_run
);

	logic [3:0] idx_q;
	logic       m_valid_q;
	logic [6:0] m_char_q;
	logic       m_last_q;

	logic       adv;
	logic       is_last;
	logic [7:0] b4_sh;
	logic [3:0] v;
	logic [6:0] ch;

	assign is_last = (idx_q == q_rdesc.last_idx);
	assign adv     = q_valid && (!m_valid_q || m_tready);
	assign q_pop   = adv && is_last;
	assign b4_sh   = q_rdesc.data >> {~idx_q[1:0], 1'b0};

	// select the digit value for radix modes
	always_comb begin
		case (q_rdesc.mode)
			btad_pkg::MODE_OCT: begin
				case (idx_q)
					4'd0:    v = {2'b00, q_rdesc.data[7:6]};
					4'd1:    v = {1'b0, q_rdesc.data[5:3]};
					default: v = {1'b0, q_rdesc.data[2:0]};
				endcase
			end
			btad_pkg::MODE_B4:  v = {2'b00, b4_sh[1:0]};
			btad_pkg::MODE_BIN: v = {3'b000, q_rdesc.data[~idx_q[2:0]]};
			default:            v = idx_q[0] ? q_rdesc.data[3:0] : q_rdesc.data[7:4];
		endcase
	end

	// pick the character
	always_comb begin
		if (q_rdesc.flush || (q_rdesc.nl && is_last)) begin
			ch = btad_pkg::CH_NL;
		end else if (q_rdesc.mode == btad_pkg::MODE_DEC) begin
			case (idx_q)
				4'd0: begin
					ch = (q_rdesc.hund != 2'd0) ?
						(btad_pkg::CH_ZERO + 7'(q_rdesc.hund)) : btad_pkg::CH_SP;
				end
				4'd1: begin
					ch = ((q_rdesc.hund != 2'd0) || (q_rdesc.tens != 4'd0)) ?
						(btad_pkg::CH_ZERO + 7'(q_rdesc.tens)) : btad_pkg::CH_SP;
				end
				4'd2:    ch = btad_pkg::CH_ZERO + 7'(q_rdesc.ones);
				default: ch = btad_pkg::CH_SP;
			endcase
		end else begin
			ch = btad_pkg::digit_char(v);
		end
	end

	// advance the character index and load the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q     <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				idx_q     <= is_last ? 4'd0 : (idx_q + 4'd1);
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_char_q <= ch;
			m_last_q <= is_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, m_char_q};
	assign m_tlast  = m_last_q;

endmodule

### rtl/byte_to_ascii_digit_dump_unit.sv
// ----------------------------------------------------------------------------
// byte_to_ascii_digit_dump_unit: byte to ASCII digit dump with line wrap
// Start: the descriptor is queued, then the first character is registered.
// Throughput: one character per cycle while the output is taken; a data byte
//   gives 2 to 9 characters (digits plus an optional newline), a flush 1 or 0.
// Input beats are taken every cycle while the 4-entry descriptor queue has room.
// Reset: clears queue, output valid, column count; hex mode, line 64.
// ----------------------------------------------------------------------------
module byte_to_ascii_digit_dump_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // data_byte
	input  logic                           s_tuser,   // action
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // char_code, zero pad
	output logic                           m_tlast,   // last_of_run
	input  logic                           cfg_we,
	input  logic [btad_pkg::REG_IDX_W-1:0] cfg_index,
	input  logic [btad_pkg::LINE_W-1:0]    cfg_wdata
);

	logic            q_full;
	logic            q_push;
	logic            q_pop;
	logic            q_valid;
	btad_pkg::desc_t q_wdesc;
	btad_pkg::desc_t q_rdesc;

	// classify input beats
	btad_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_wdesc   (q_wdesc)
	);

	// decouple front and back
	btad_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdesc  (q_wdesc),
		.full   (q_full),
		.pop    (q_pop),
		.rdesc  (q_rdesc),
		.valid  (q_valid)
	);

	// serialize characters
	btad_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_rdesc  (q_rdesc),
		.q_pop    (q_pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

`ifndef SYNTH
	// a newline always closes a run
	a_nl_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[6:0] == btad_pkg::CH_NL)) |-> m_tlast)
		else $error("newline beat without tlast");

	// a run in flight keeps its descriptor at the queue head
	a_run_held: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> q_valid)
		else $error("descriptor popped before its last character");

	// a full queue stalls the input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> (!s_tready && q_valid))
		else $error("input taken with full queue");
`endif

endmodule
